// ===== hdl/assert_macros.svh =====
// assertion helpers, clocked on i_clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that holds at every edge
`define VN_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define VN_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/vn_pkg.sv =====
package vn_pkg;

    localparam int N_LANES       = 4;
    localparam int MODE_W        = 2;
    localparam int COMP_W        = 32;
    localparam int MAG_W         = 32;
    localparam int SQ_W          = 2 * MAG_W;
    localparam int SUM_W         = SQ_W + 2;
    localparam int ROOT_W        = SUM_W / 2;
    localparam int REM_W         = ROOT_W + 3;
    localparam int OUT_FRAC_BITS = 14;
    localparam int UNIT_W        = 16;
    localparam int DIV_BITS      = OUT_FRAC_BITS + 1;
    localparam int CMP_W         = ROOT_W + DIV_BITS;
    localparam int SAT_W         = (DIV_BITS > UNIT_W + 1) ? DIV_BITS : UNIT_W + 1;
    localparam int FRONT_LAT     = 2;
    localparam int SUM_LAT       = 2;
    localparam int SQRT_LAT      = SUM_LAT + ROOT_W;
    localparam int PIPE_LAT      = FRONT_LAT + SQRT_LAT + DIV_BITS + 1;

    localparam logic [MODE_W-1:0] MODE_2D = 2'd0;
    localparam logic [MODE_W-1:0] MODE_3D = 2'd1;
    localparam logic [MODE_W-1:0] MODE_4D = 2'd2;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             used;
    } t_side;

endpackage

// ===== hdl/vector_normalize_core.sv =====
// pipeline: an accepted item passes the square, sum and root, divide and output stages in
// that order; its depth is set by the one-bit-per-stage root and quotient pipelines
// throughput: one item per cycle; a stalled output freezes the whole pipeline
// reset: synchronous active-low i_rst_n clears all valid flags, no data is reset
module vector_normalize_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // comp_x, comp_y, comp_z, comp_w
    input  logic [1:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // unit_x, unit_y, unit_z, unit_w, length, zero pad
    output logic [0:0]   m_axis_tuser   // zero_length
);
    import vn_pkg::*;

    logic [PIPE_LAT-1:0] r_vld;
    logic                w_en;
    logic                w_used [N_LANES];
    t_side               w_side [N_LANES];
    logic [SQ_W-1:0]     w_sq   [N_LANES];
    logic [ROOT_W-1:0]   w_len;
    t_side               r_side_d [SQRT_LAT][N_LANES];
    logic [ROOT_W-1:0]   r_len_d  [DIV_BITS+1];
    logic [UNIT_W-1:0]   w_unit [N_LANES];
    logic [MODE_W-1:0]   w_mode;

    assign w_en          = !r_vld[PIPE_LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_mode        = s_axis_tuser;

    always_comb begin
        w_used[0] = 1'b1;
        w_used[1] = 1'b1;
        w_used[2] = (w_mode != MODE_2D);
        w_used[3] = (w_mode != MODE_2D) && (w_mode != MODE_3D);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], s_axis_tvalid};
        end
    end

    for (genvar i = 0; i < N_LANES; i++) begin : g_lane
        vn_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_comp (s_axis_tdata[i*COMP_W +: COMP_W]),
            .i_used (w_used[i]),
            .o_side (w_side[i]),
            .o_sq   (w_sq[i])
        );

        vn_div_lane u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_side (r_side_d[SQRT_LAT-1][i]),
            .i_len  (w_len),
            .o_unit (w_unit[i])
        );
    end

    // hold magnitudes while the root is formed
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < N_LANES; i++) begin
                r_side_d[0][i] <= w_side[i];
                for (int s = 1; s < SQRT_LAT; s++) begin
                    r_side_d[s][i] <= r_side_d[s-1][i];
                end
            end
        end
    end

    vn_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_sq  (w_sq),
        .o_len (w_len)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_len_d[0] <= w_len;
            for (int s = 1; s <= DIV_BITS; s++) begin
                r_len_d[s] <= r_len_d[s-1];
            end
        end
    end

    assign m_axis_tvalid = r_vld[PIPE_LAT-1];
    assign m_axis_tdata  = {7'd0, r_len_d[DIV_BITS],
                            w_unit[3], w_unit[2], w_unit[1], w_unit[0]};
    assign m_axis_tuser  = (r_len_d[DIV_BITS] == '0);

    `include "assert_macros.svh"

    `VN_IMPLY(a_zero_units, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[63:0] == 64'd0)
    `VN_IMPLY(a_len_top, m_axis_tvalid && m_axis_tdata[96], m_axis_tdata[95:64] == 32'd0)
    `VN_CHECK(a_unit_range, !m_axis_tvalid || ($signed(m_axis_tdata[15:0]) <= 16'sd16384
        && $signed(m_axis_tdata[15:0]) >= -16'sd16384))
endmodule

// ===== hdl/vn_lane.sv =====
module vn_lane (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [vn_pkg::COMP_W-1:0] i_comp,
    input  logic                      i_used,
    output vn_pkg::t_side             o_side,
    output logic [vn_pkg::SQ_W-1:0]   o_sq
);
    import vn_pkg::*;

    t_side            r_side1;
    t_side            n_side1;
    t_side            r_side2;
    logic [SQ_W-1:0]  r_sq;
    logic [SQ_W-1:0]  n_sq;

    always_comb begin
        n_side1.neg  = i_comp[COMP_W-1];
        n_side1.mag  = i_comp[COMP_W-1] ? (~i_comp + 1'b1) : i_comp;
        n_side1.used = i_used;
        n_sq         = r_side1.used ? (SQ_W'(r_side1.mag) * SQ_W'(r_side1.mag)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= n_side1;
            r_side2 <= r_side1;
            r_sq    <= n_sq;
        end
    end

    assign o_side = r_side2;
    assign o_sq   = r_sq;
endmodule

// ===== hdl/vn_sqrt.sv =====
module vn_sqrt (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [vn_pkg::SQ_W-1:0]   i_sq [vn_pkg::N_LANES],
    output logic [vn_pkg::ROOT_W-1:0] o_len
);
    import vn_pkg::*;

    logic [SUM_W-1:0]  r_s01;
    logic [SUM_W-1:0]  r_s23;
    logic [SUM_W-1:0]  r_rad  [ROOT_W+1];
    logic [REM_W-1:0]  r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s01    <= SUM_W'(i_sq[0]) + SUM_W'(i_sq[1]);
            r_s23    <= SUM_W'(i_sq[2]) + SUM_W'(i_sq[3]);
            r_rad[0] <= r_s01 + r_s23;
            r_rem[0] <= '0;
            r_root[0] <= '0;
        end
    end

    // one root bit per stage, two radicand bits consumed from the top
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0] n_rs;
        logic [REM_W-1:0] n_t;
        logic             n_ge;

        always_comb begin
            n_rs = {r_rem[k][REM_W-3:0], r_rad[k][SUM_W-1 -: 2]};
            n_t  = {1'b0, r_root[k], 2'b01};
            n_ge = (n_rs >= n_t);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1]  <= {r_rad[k][SUM_W-3:0], 2'b00};
                r_rem[k+1]  <= n_ge ? (n_rs - n_t) : n_rs;
                r_root[k+1] <= {r_root[k][ROOT_W-2:0], n_ge};
            end
        end
    end

    assign o_len = r_root[ROOT_W];
endmodule

// ===== hdl/vn_div_lane.sv =====
module vn_div_lane (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  vn_pkg::t_side             i_side,
    input  logic [vn_pkg::ROOT_W-1:0] i_len,
    output logic [vn_pkg::UNIT_W-1:0] o_unit
);
    import vn_pkg::*;

    logic [CMP_W-1:0]    r_rem  [DIV_BITS+1];
    logic [DIV_BITS-1:0] r_q    [DIV_BITS+1];
    logic [ROOT_W-1:0]   r_len  [DIV_BITS+1];
    logic                r_neg  [DIV_BITS+1];
    logic                r_used [DIV_BITS+1];
    logic [UNIT_W-1:0]   r_unit;
    logic [UNIT_W-1:0]   n_unit;
    logic [SAT_W-1:0]    n_qe;

    always_comb begin
        r_rem[0]  = CMP_W'(i_side.mag) << OUT_FRAC_BITS;
        r_q[0]    = '0;
        r_len[0]  = i_len;
        r_neg[0]  = i_side.neg;
        r_used[0] = i_side.used;
    end

    // restoring division, quotient msb first
    for (genvar j = 0; j < DIV_BITS; j++) begin : g_stage
        localparam int K = DIV_BITS - 1 - j;
        logic [CMP_W-1:0] n_d;
        logic             n_ge;

        always_comb begin
            n_d  = CMP_W'(r_len[j]) << K;
            n_ge = (r_rem[j] >= n_d);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= n_ge ? (r_rem[j] - n_d) : r_rem[j];
                r_q[j+1]    <= r_q[j] | (DIV_BITS'(n_ge) << K);
                r_len[j+1]  <= r_len[j];
                r_neg[j+1]  <= r_neg[j];
                r_used[j+1] <= r_used[j];
            end
        end
    end

    always_comb begin
        n_qe = SAT_W'(r_q[DIV_BITS]);
        if (!r_used[DIV_BITS] || r_len[DIV_BITS] == '0) begin
            n_unit = '0;
        end else if (r_neg[DIV_BITS]) begin
            n_unit = (n_qe > SAT_W'(32768)) ? 16'h8000 : UNIT_W'(~n_qe + 1'b1);
        end else begin
            n_unit = (n_qe > SAT_W'(32767)) ? 16'h7fff : UNIT_W'(n_qe);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_unit <= n_unit;
        end
    end

    assign o_unit = r_unit;
endmodule
